// ----- rtl/kms_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Key matrix scanner package
// Shared constants, control word types and the sequencer program.
// ----------------------------------------------------------------------------
package kms_pkg;

  // Matrix geometry of the key map and the pressed-key store.
  localparam int NUM_ROWS = 4;
  localparam int NUM_COLS = 8;
  localparam int ROW_W = 2;
  localparam int COL_W = 3;
  localparam int POS_W = ROW_W + COL_W;
  localparam int CODE_W = 8;
  localparam int LEVELS_W = 4;
  localparam int ROW_COUNT_W = 3;
  localparam int COL_COUNT_W = 4;

  // Defaults of the matrix size limits.
  localparam int MAX_ROWS_DEFAULT = 4;
  localparam int MAX_COLUMNS_DEFAULT = 8;

  // Configuration port.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_INDEX_W-1:0] REG_ROW_COUNT = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COLUMN_COUNT = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_MAP_0 = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_MAP_1 = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_MAP_2 = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_MAP_3 = 3'd5;

  localparam logic [ROW_COUNT_W-1:0] ROW_COUNT_RESET = 3'd4;
  localparam logic [COL_COUNT_W-1:0] COL_COUNT_RESET = 4'd8;

  // Position of the trigger key: row 0, column 1.
  localparam logic [POS_W-1:0] TRIGGER_POS = 5'd1;

  // Sequencer program.
  localparam int STEP_W = 2;
  typedef logic [STEP_W-1:0] step_t;

  typedef enum logic [1:0] {
    OP_ACCEPT,
    OP_EVAL,
    OP_EMIT_NULL,
    OP_EMIT_EVENT
  } op_t;

  typedef enum logic [1:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_CHANGE,
    COND_MORE
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ctrl_word_t;

  // Control handed to the datapath.
  typedef struct packed {
    op_t  op;
    logic fire;
  } ctrl_t;

  // Status returned by the datapath.
  typedef struct packed {
    logic out_free;
    logic any_change;
    logic more;
  } status_t;

  localparam step_t STEP_ACCEPT = 2'd0;
  localparam step_t STEP_EVAL = 2'd1;
  localparam step_t STEP_NULL = 2'd2;
  localparam step_t STEP_EMIT = 2'd3;

  // Program ROM. A step jumps to its target when its condition holds and
  // falls through to the next step otherwise; the last step wraps to the first.
  function automatic ctrl_word_t program_rom(input step_t step);
    ctrl_word_t cw;
    unique case (step)
      STEP_ACCEPT: cw = '{op: OP_ACCEPT,     cond: COND_NEVER,  target: STEP_EVAL};
      STEP_EVAL:   cw = '{op: OP_EVAL,       cond: COND_CHANGE, target: STEP_EMIT};
      STEP_NULL:   cw = '{op: OP_EMIT_NULL,  cond: COND_ALWAYS, target: STEP_ACCEPT};
      STEP_EMIT:   cw = '{op: OP_EMIT_EVENT, cond: COND_MORE,   target: STEP_EMIT};
      default:     cw = '{op: OP_ACCEPT,     cond: COND_NEVER,  target: STEP_EVAL};
    endcase
    return cw;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/key_matrix_scanner.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Key matrix scanner
// Turns per-column row samples into key press and release transactions.
// ----------------------------------------------------------------------------
// Each input transaction on row_levels is the row sample of the column that
// the internal column pointer selects; the pointer wraps at the configured
// column count. Active rows are compared with their stored pressed bits, and
// each change gives one result transaction in ascending row order carrying
// the mapped key code. A sample without changes gives one result with
// event_valid low. is_last marks the final result of a sample.
// Flow: the accept step captures the sample in a register, the eval step
// updates the pressed bits and the change mask, and each result then goes
// through the single result register; a sample gives one to four results,
// at least one even without changes. The program sequencer
// works on one sample at a time; in_ready is high only in its accept step.
// If the receiver stalls, the result register holds and the sequencer waits.
// Configuration writes on cfg_write/cfg_index/cfg_data take effect at once.
// Reset clears all pressed bits, the column pointer and the result valid
// flag, and loads the default row and column counts.
// ----------------------------------------------------------------------------
module key_matrix_scanner #(
  parameter int MAX_ROWS    = kms_pkg::MAX_ROWS_DEFAULT,
  parameter int MAX_COLUMNS = kms_pkg::MAX_COLUMNS_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_write,
  input  wire logic [kms_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [kms_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [kms_pkg::LEVELS_W-1:0]    row_levels,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic                                 event_valid,
  output logic [kms_pkg::CODE_W-1:0]           key_code,
  output logic                                 pressed,
  output logic [kms_pkg::COL_W-1:0]            scanned_column,
  output logic                                 trigger_active,
  output logic                                 is_last
);

  kms_pkg::ctrl_t   ctrl;
  kms_pkg::status_t status;

  // Program sequencer.
  kms_sequencer u_sequencer (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .status   (status),
    .ctrl     (ctrl),
    .in_ready (in_ready)
  );

  // Scan datapath.
  kms_datapath #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .ctrl           (ctrl),
    .status         (status),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .row_levels     (row_levels),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .event_valid    (event_valid),
    .key_code       (key_code),
    .pressed        (pressed),
    .scanned_column (scanned_column),
    .trigger_active (trigger_active),
    .is_last        (is_last)
  );

endmodule
`default_nettype wire

// ----- rtl/kms_sequencer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Key matrix scanner sequencer
// Step counter over the program ROM with conditional jumps.
// ----------------------------------------------------------------------------
module kms_sequencer (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire kms_pkg::status_t status,
  output kms_pkg::ctrl_t        ctrl,
  output logic                  in_ready
);

  kms_pkg::step_t      step;
  kms_pkg::step_t      step_next;
  kms_pkg::ctrl_word_t cw;
  logic                done;
  logic                cond_true;

  assign cw = kms_pkg::program_rom(step);

  // A step completes when its action can take place this cycle.
  always_comb begin
    unique case (cw.op)
      kms_pkg::OP_ACCEPT:     done = in_valid;
      kms_pkg::OP_EVAL:       done = 1'b1;
      kms_pkg::OP_EMIT_NULL:  done = status.out_free;
      kms_pkg::OP_EMIT_EVENT: done = status.out_free;
      default:                done = 1'b0;
    endcase
  end

  // Jump condition decode.
  always_comb begin
    unique case (cw.cond)
      kms_pkg::COND_NEVER:  cond_true = 1'b0;
      kms_pkg::COND_ALWAYS: cond_true = 1'b1;
      kms_pkg::COND_CHANGE: cond_true = status.any_change;
      kms_pkg::COND_MORE:   cond_true = status.more;
      default:              cond_true = 1'b0;
    endcase
  end

  // Next step: hold, jump or fall through.
  always_comb begin
    step_next = step;
    if (done) begin
      step_next = cond_true ? cw.target : step + kms_pkg::STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= kms_pkg::STEP_ACCEPT;
    end else begin
      step <= step_next;
    end
  end

  assign ctrl.op   = cw.op;
  assign ctrl.fire = done;
  assign in_ready  = (cw.op == kms_pkg::OP_ACCEPT);

endmodule
`default_nettype wire

// ----- rtl/kms_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Key matrix scanner datapath
// Configuration registers, pressed-key store, column pointer and result register.
// ----------------------------------------------------------------------------
module kms_datapath #(
  parameter int MAX_ROWS    = kms_pkg::MAX_ROWS_DEFAULT,
  parameter int MAX_COLUMNS = kms_pkg::MAX_COLUMNS_DEFAULT
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire kms_pkg::ctrl_t                      ctrl,
  output kms_pkg::status_t                         status,
  input  wire logic                                cfg_write,
  input  wire logic [kms_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [kms_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  wire logic [kms_pkg::LEVELS_W-1:0]        row_levels,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic                                     event_valid,
  output logic [kms_pkg::CODE_W-1:0]               key_code,
  output logic                                     pressed,
  output logic [kms_pkg::COL_W-1:0]                scanned_column,
  output logic                                     trigger_active,
  output logic                                     is_last
);

  localparam int ROW_CAP = (MAX_ROWS < kms_pkg::NUM_ROWS) ? MAX_ROWS : kms_pkg::NUM_ROWS;
  localparam int COL_CAP_RAW = (MAX_COLUMNS < kms_pkg::NUM_COLS) ? MAX_COLUMNS
                                                                  : kms_pkg::NUM_COLS;
  localparam int COL_CAP = (COL_CAP_RAW < 1) ? 1 : COL_CAP_RAW;

  logic [kms_pkg::ROW_COUNT_W-1:0]                row_count;
  logic [kms_pkg::COL_COUNT_W-1:0]                column_count;
  logic [kms_pkg::NUM_ROWS-1:0][kms_pkg::CFG_DATA_W-1:0] key_map;
  logic [kms_pkg::NUM_ROWS*kms_pkg::NUM_COLS-1:0] key_pressed;
  logic [kms_pkg::COL_W-1:0]                      column_pointer;
  logic [kms_pkg::LEVELS_W-1:0]                   levels;
  logic [kms_pkg::COL_W-1:0]                      column;
  logic [kms_pkg::NUM_ROWS-1:0]                   change_mask;

  logic [kms_pkg::ROW_COUNT_W-1:0]                rows_eff;
  logic [kms_pkg::COL_COUNT_W-1:0]                cols_nonzero;
  logic [kms_pkg::COL_COUNT_W-1:0]                cols_eff;
  logic [kms_pkg::COL_W-1:0]                      col_eff;
  logic [kms_pkg::COL_COUNT_W-1:0]                col_plus;
  logic [kms_pkg::COL_W-1:0]                      pointer_next;
  logic [kms_pkg::NUM_ROWS-1:0]                   change_vec;
  logic [kms_pkg::NUM_ROWS*kms_pkg::NUM_COLS-1:0] key_pressed_next;
  logic [kms_pkg::ROW_W-1:0]                      pick;
  logic [kms_pkg::NUM_ROWS-1:0]                   rest_mask;
  logic                                           out_free;

  // Effective matrix size and the column that this sample belongs to.
  always_comb begin
    rows_eff = (row_count > kms_pkg::ROW_COUNT_W'(ROW_CAP))
             ? kms_pkg::ROW_COUNT_W'(ROW_CAP) : row_count;
    cols_nonzero = (column_count == '0) ? kms_pkg::COL_COUNT_W'(1) : column_count;
    cols_eff = (cols_nonzero > kms_pkg::COL_COUNT_W'(COL_CAP))
             ? kms_pkg::COL_COUNT_W'(COL_CAP) : cols_nonzero;
    col_eff = ({1'b0, column_pointer} < cols_eff) ? column_pointer : '0;
    col_plus = {1'b0, col_eff} + kms_pkg::COL_COUNT_W'(1);
    pointer_next = (col_plus >= cols_eff) ? '0 : col_plus[kms_pkg::COL_W-1:0];
  end

  // Compare every active row of the column with its pressed bit.
  always_comb begin
    key_pressed_next = key_pressed;
    for (int r = 0; r < kms_pkg::NUM_ROWS; r++) begin
      change_vec[r] = (kms_pkg::ROW_COUNT_W'(r) < rows_eff)
                    && ((!levels[r]) != key_pressed[{kms_pkg::ROW_W'(r), col_eff}]);
      if (change_vec[r]) begin
        key_pressed_next[{kms_pkg::ROW_W'(r), col_eff}] = !levels[r];
      end
    end
  end

  // Lowest pending row and the rows still pending after it.
  always_comb begin
    pick = '0;
    for (int r = kms_pkg::NUM_ROWS - 1; r >= 0; r--) begin
      if (change_mask[r]) begin
        pick = kms_pkg::ROW_W'(r);
      end
    end
    rest_mask = change_mask;
    rest_mask[pick] = 1'b0;
  end

  assign out_free          = !out_valid || out_ready;
  assign status.out_free   = out_free;
  assign status.any_change = |change_vec;
  assign status.more       = |rest_mask;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count    <= kms_pkg::ROW_COUNT_RESET;
      column_count <= kms_pkg::COL_COUNT_RESET;
      key_map      <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        kms_pkg::REG_ROW_COUNT:    row_count <= cfg_data[kms_pkg::ROW_COUNT_W-1:0];
        kms_pkg::REG_COLUMN_COUNT: column_count <= cfg_data[kms_pkg::COL_COUNT_W-1:0];
        kms_pkg::REG_KEY_MAP_0:    key_map[0] <= cfg_data;
        kms_pkg::REG_KEY_MAP_1:    key_map[1] <= cfg_data;
        kms_pkg::REG_KEY_MAP_2:    key_map[2] <= cfg_data;
        kms_pkg::REG_KEY_MAP_3:    key_map[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Scan state: pressed bits, column pointer and the pending event rows.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_pressed    <= '0;
      column_pointer <= '0;
      change_mask    <= '0;
    end else if (ctrl.fire) begin
      unique case (ctrl.op)
        kms_pkg::OP_EVAL: begin
          key_pressed    <= key_pressed_next;
          column_pointer <= pointer_next;
          change_mask    <= change_vec;
        end
        kms_pkg::OP_EMIT_EVENT: begin
          change_mask <= rest_mask;
        end
        default: ;
      endcase
    end
  end

  // Sample capture.
  always_ff @(posedge clk) begin
    if (ctrl.fire && ctrl.op == kms_pkg::OP_ACCEPT) begin
      levels <= row_levels;
    end
    if (ctrl.fire && ctrl.op == kms_pkg::OP_EVAL) begin
      column <= col_eff;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.fire && (ctrl.op == kms_pkg::OP_EMIT_NULL
                               || ctrl.op == kms_pkg::OP_EMIT_EVENT)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (ctrl.fire && ctrl.op == kms_pkg::OP_EMIT_EVENT) begin
      event_valid    <= 1'b1;
      key_code       <= key_map[pick][{column, 3'b000} +: kms_pkg::CODE_W];
      pressed        <= !levels[pick];
      scanned_column <= column;
      trigger_active <= key_pressed[kms_pkg::TRIGGER_POS];
      is_last        <= !(|rest_mask);
    end else if (ctrl.fire && ctrl.op == kms_pkg::OP_EMIT_NULL) begin
      event_valid    <= 1'b0;
      key_code       <= '0;
      pressed        <= 1'b0;
      scanned_column <= column;
      trigger_active <= key_pressed[kms_pkg::TRIGGER_POS];
      is_last        <= 1'b1;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/kms_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Key matrix scanner checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module kms_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic                          event_valid,
  input wire logic [kms_pkg::CODE_W-1:0]    key_code,
  input wire logic                          pressed,
  input wire logic [kms_pkg::COL_W-1:0]     scanned_column,
  input wire logic                          trigger_active,
  input wire logic                          is_last
);

  // The result register is empty right after reset.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result keeps its payload.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(key_code) && $stable(pressed)
      && $stable(event_valid) && $stable(is_last) && $stable(scanned_column)
      && $stable(trigger_active))
    else $error("stalled result changed");

  // A result without an event is always the only result of its sample.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !event_valid |-> is_last)
    else $error("empty result not last");

  // A result without an event carries a zero code and no press.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !event_valid |-> key_code == '0 && !pressed)
    else $error("empty result carries data");

  // No new sample is taken while a result that is not the last of its sample is held.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_last |-> !in_ready)
    else $error("input accepted during a burst of events");

endmodule

bind key_matrix_scanner kms_checker u_kms_checker (
  .clk            (clk),
  .rst            (rst),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .event_valid    (event_valid),
  .key_code       (key_code),
  .pressed        (pressed),
  .scanned_column (scanned_column),
  .trigger_active (trigger_active),
  .is_last        (is_last)
);
`default_nettype wire
